// ===== rtl/tdf_pkg.sv =====
// package for the trial division factorizer
// holds controller states and the command and status structs; no dependencies
package tdf_pkg;

  localparam int NumberBitsDefault = 31;

  typedef enum logic [2:0] {
    StIdle,
    StDivInit,
    StDivRun,
    StDecide,
    StEmit
  } state_e;

  typedef struct packed {
    logic load;      // take a new number, divisor back to two
    logic div_init;  // seed the divider with the current value
    logic div_step;  // one restoring division step
    logic take_quo;  // divisor divides: value becomes the quotient, emit divisor
    logic inc_d;     // try the next divisor
    logic emit_rest; // emit the remaining value as the final factor
  } cmd_t;

  typedef struct packed {
    logic div_done;  // last division step is in progress
    logic d_gt_q;    // divisor above quotient: no more divisors to try
    logic rem_zero;  // divisor divides the value
    logic last;      // held result is the final factor
  } status_t;

endpackage

// ===== rtl/tdf_dpath.sv =====
// datapath: value and divisor registers, bit-serial restoring divider,
// result register; depends on tdf_pkg
module tdf_dpath import tdf_pkg::*; #(
  parameter int NumberBits = NumberBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  input  logic [NumberBits-1:0] number_i,
  output status_t               status_o,
  output logic [NumberBits-1:0] factor_o,
  output logic                  last_o
);

  localparam int CntW = $clog2(NumberBits);
  localparam logic [CntW-1:0] LastStep = CntW'(NumberBits - 1);

  logic [NumberBits-1:0] n_q, n_d;
  logic [NumberBits-1:0] d_q, d_d;
  logic [NumberBits-1:0] rem_q, rem_d;
  logic [NumberBits-1:0] quo_q, quo_d;
  logic [NumberBits-1:0] factor_q, factor_d;
  logic                  last_q, last_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  logic [NumberBits:0] trial;
  logic [NumberBits:0] diff;

  // shift in the next dividend bit and subtract if it fits
  assign trial = {rem_q, quo_q[NumberBits-1]};
  assign diff  = trial - {1'b0, d_q};

  always_comb begin
    n_d      = n_q;
    d_d      = d_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    factor_d = factor_q;
    last_d   = last_q;
    if (cmd_i.load) begin
      n_d = number_i;
      d_d = NumberBits'(2);
    end
    if (cmd_i.div_init) begin
      rem_d = '0;
      quo_d = n_q;
      cnt_d = '0;
    end
    if (cmd_i.div_step) begin
      if (!diff[NumberBits]) begin
        rem_d = diff[NumberBits-1:0];
        quo_d = {quo_q[NumberBits-2:0], 1'b1};
      end else begin
        rem_d = trial[NumberBits-1:0];
        quo_d = {quo_q[NumberBits-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
    end
    if (cmd_i.take_quo) begin
      n_d      = quo_q;
      factor_d = d_q;
      last_d   = 1'b0;
    end
    if (cmd_i.inc_d) begin
      d_d = d_q + 1'b1;
    end
    if (cmd_i.emit_rest) begin
      factor_d = n_q;
      last_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    d_q      <= d_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    factor_q <= factor_d;
    last_q   <= last_d;
  end

  assign status_o.div_done = (cnt_q == LastStep);
  assign status_o.d_gt_q   = (d_q > quo_q);
  assign status_o.rem_zero = (rem_q == '0);
  assign status_o.last     = last_q;

  assign factor_o = factor_q;
  assign last_o   = last_q;

endmodule

// ===== rtl/tdf_ctrl.sv =====
// controller state machine for the trial division factorizer
// sequences division trials and result transactions; depends on tdf_pkg
module tdf_ctrl import tdf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StDivInit;
      end
      StDivInit: state_d = StDivRun;
      StDivRun: begin
        if (status_i.div_done) state_d = StDecide;
      end
      StDecide: begin
        priority if (status_i.d_gt_q) state_d = StEmit;
        else if (status_i.rem_zero) state_d = StEmit;
        else state_d = StDivInit;
      end
      StEmit: begin
        if (out_ready_i) state_d = status_i.last ? StIdle : StDivInit;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      StDivInit: cmd_o.div_init = 1'b1;
      StDivRun:  cmd_o.div_step = 1'b1;
      StDecide: begin
        priority if (status_i.d_gt_q) cmd_o.emit_rest = 1'b1;
        else if (status_i.rem_zero) cmd_o.take_quo = 1'b1;
        else cmd_o.inc_d = 1'b1;
      end
      StEmit: out_valid_o = 1'b1;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/trial_division_factorizer.sv =====
// trial division factorizer: one number in, its prime factors out in order (0 and 1 come out as themselves)
// each trial divisor passes through the divider init state, a bit-serial restoring division
// over every bit of the value and a decide state; each factor is held in the emit state until
// the sink is ready; trial divisors run up to sqrt(n)
// one item at a time; a new number is taken only after its last factor transaction
// reset clears the controller to idle and the step counter; other datapath regs are not reset
module trial_division_factorizer import tdf_pkg::*; #(
  parameter int NUMBER_BITS = NumberBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [NUMBER_BITS-1:0] number_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [NUMBER_BITS-1:0] factor_o,
  output logic                   last_o
);

  cmd_t    cmd;
  status_t status;

  tdf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tdf_dpath #(
    .NumberBits (NUMBER_BITS)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .number_i (number_i),
    .status_o (status),
    .factor_o (factor_o),
    .last_o   (last_o)
  );

endmodule

// ===== sim/trial_division_factorizer_tb.sv =====
// testbench for trial_division_factorizer: directed table, then random numbers
// factor transactions are checked against typed-in factors or an in-bench trial division predictor
// depends on tdf_pkg and the rtl top level only
`timescale 1ns / 1ps

module trial_division_factorizer_tb;
  import tdf_pkg::*;

  localparam int NB = NumberBitsDefault;
  localparam longint unsigned MAX_VALUE = (64'd1 << NB) - 1;
  localparam int RANDOM_ITEMS = 77;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES = 3000;
  localparam int HOLD_AFTER = 40;
  localparam int NUM_PROBES = 23;
  localparam int SMALL_PRIMES [25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                        43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

  typedef struct {
    logic [NB-1:0] factor;
    logic          last;
  } factor_t;

  // known set: the single factor of the number is typed in, else predicted
  typedef struct packed {
    logic [NB-1:0] number;
    logic          known;
    logic [NB-1:0] factor;
  } probe_t;

  localparam probe_t PROBES [NUM_PROBES] = '{
    '{31'd0,          1'b1, 31'd0},
    '{31'd1,          1'b1, 31'd1},
    '{31'd2,          1'b1, 31'd2},
    '{31'd3,          1'b1, 31'd3},
    '{31'd4,          1'b0, 31'd0},
    '{31'd5,          1'b1, 31'd5},
    '{31'd6,          1'b0, 31'd0},
    '{31'd7,          1'b1, 31'd7},
    '{31'd8,          1'b0, 31'd0},
    '{31'd9,          1'b0, 31'd0},
    '{31'd12,         1'b0, 31'd0},
    '{31'd25,         1'b0, 31'd0},
    '{31'd49,         1'b0, 31'd0},
    '{31'd97,         1'b1, 31'd97},
    '{31'd1024,       1'b0, 31'd0},
    '{31'd65535,      1'b0, 31'd0},
    '{31'd510510,     1'b0, 31'd0},
    '{31'd994009,     1'b0, 31'd0},
    '{31'd1000003,    1'b1, 31'd1000003},
    '{31'd2000006,    1'b0, 31'd0},
    '{31'd1073741824, 1'b0, 31'd0},
    '{31'd1162261467, 1'b0, 31'd0},
    '{31'd2147483646, 1'b0, 31'd0}
  };

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  logic [NB-1:0] number_i;
  logic          out_valid_o;
  logic          out_ready_i;
  logic [NB-1:0] factor_o;
  logic          last_o;

  factor_t factor_q [$];
  factor_t next_factor;
  int      error_count;
  int      out_count;
  int      cycle_count;

  trial_division_factorizer #(
    .NUMBER_BITS(NB)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .number_i   (number_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .factor_o   (factor_o),
    .last_o     (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void predict_factors(input logic [NB-1:0] number);
    longint unsigned rest;
    longint unsigned d;
    rest = 64'(number);
    d    = 2;
    // stop once the divisor passes the square root of what is left
    while (d <= rest / d) begin
      if (rest % d == 0) begin
        factor_q.push_back('{factor: NB'(d), last: 1'b0});
        rest = rest / d;
      end else begin
        d++;
      end
    end
    factor_q.push_back('{factor: NB'(rest), last: 1'b1});
  endfunction

  // product of random small primes, kept at or below bound
  function automatic longint unsigned smooth_number(input longint unsigned bound);
    longint unsigned n;
    int              k;
    int              p;
    n = 1;
    k = $urandom_range(1, 30);
    for (int i = 0; i < k; i++) begin
      p = ($urandom_range(0, 2) == 0) ? 2 : SMALL_PRIMES[5'($urandom_range(0, 24))];
      if (n * 64'(p) > bound) break;
      n = n * 64'(p);
    end
    return n;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  task automatic note_mismatch(input string what);
    error_count++;
    if (error_count <= 10) $display("%0t: %s", $time, what);
  endtask

  task automatic send_number(input logic [NB-1:0] value, input logic known,
                             input logic [NB-1:0] known_factor);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    number_i   <= value;
    do @(posedge clk_i); while (!in_ready_o);
    if (known) begin
      factor_q.push_back('{factor: known_factor, last: 1'b1});
    end else begin
      predict_factors(value);
    end
  endtask

  // factor transaction checker
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      out_count++;
      if (factor_q.size() == 0) begin
        note_mismatch($sformatf("unexpected factor %0d last %0b", factor_o, last_o));
      end else begin
        next_factor = factor_q.pop_front();
        if (factor_o !== next_factor.factor || last_o !== next_factor.last) begin
          note_mismatch($sformatf("expected factor %0d last %0b, got factor %0d last %0b",
                                  next_factor.factor, next_factor.last, factor_o, last_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("trial_division_factorizer_tb: errors");
      $finish;
    end
  end

  // sink side: random stalls, one long hold-off so the block backs up its input
  initial begin
    int run;
    int gap;
    bit held;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 8);
      out_ready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
      if (!held && out_count >= HOLD_AFTER) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end else begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 3);
      end
      out_ready_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  end

  initial begin
    longint unsigned value;
    longint unsigned mult;
    int              kind;
    error_count = 0;
    out_count   = 0;
    cycle_count = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    number_i    <= '0;
    out_ready_i <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NUM_PROBES; i++) begin
      send_number(PROBES[i].number, PROBES[i].known, PROBES[i].factor);
    end

    // mostly small or smooth numbers: a large prime cofactor would take too long
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        value = 64'($urandom_range(0, 4095));
      end else if (kind < 7) begin
        value = smooth_number(MAX_VALUE);
      end else begin
        mult  = 64'($urandom_range(2, 4095));
        value = smooth_number(MAX_VALUE / mult) * mult;
      end
      send_number(NB'(value), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (factor_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (factor_q.size() != 0) begin
      note_mismatch($sformatf("%0d factors never arrived", factor_q.size()));
    end
    if (error_count == 0) begin
      $display("trial_division_factorizer_tb: clean");
    end else begin
      $display("trial_division_factorizer_tb: errors");
    end
    $finish;
  end

endmodule
